// File: hw/rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, limits, register codes and reset values for the PID core.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 32;
	localparam int DT_W      = 24;
	localparam int OUT_W     = 24;
	localparam int INTEG_W   = 22;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_W   = DATA_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DIV_W   = DATA_W + 1 + FRAC_BITS;
	localparam int ISUM_W  = DATA_W + DT_W - FRAC_BITS + 1;
	localparam int TERM_W  = 2 * DATA_W - FRAC_BITS;
	localparam int SUM_W   = TERM_W + 2;
	localparam int MCNT_W  = $clog2(MUL_W + 1);
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	localparam logic signed [ISUM_W-1:0] ILIM = ISUM_W'(30) <<< FRAC_BITS;
	localparam logic signed [SUM_W-1:0]  OLIM = SUM_W'(200) <<< FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DT = 2'd3;

	localparam logic [GAIN_W-1:0] KP_RESET = 32'd65536;
	localparam logic [GAIN_W-1:0] KI_RESET = 32'd0;
	localparam logic [GAIN_W-1:0] KD_RESET = 32'd0;
	localparam logic [DT_W-1:0]   DT_RESET = 24'd655;

	localparam logic [OUT_W-1:0]  OUT_MAX = 24'd13107200;

endpackage

// File: hw/rtl/pidaw_mul.sv
// ----------------------------------------------------------------------------
// pidaw_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, sign bit last.
// ----------------------------------------------------------------------------
module pidaw_mul (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [pidaw_pkg::MUL_W-1:0]     a,
	input  logic signed [pidaw_pkg::MUL_W-1:0]     b,
	output logic                                   done,
	output logic signed [pidaw_pkg::PROD_W-1:0]    product
);

	localparam int W = pidaw_pkg::MUL_W;

	logic                          run_q;
	logic                          done_q;
	logic [pidaw_pkg::MCNT_W-1:0]  cnt_q;
	logic signed [W-1:0]           a_q;
	logic [W-1:0]                  b_q;
	logic signed [W:0]             hi_q;
	logic [W-1:0]                  lo_q;
	logic                          last;
	logic signed [W+1:0]           a_ext;
	logic signed [W+1:0]           addend;
	logic signed [W+1:0]           sum;

	assign last  = (cnt_q == pidaw_pkg::MCNT_W'(W - 1));
	assign a_ext = {{2{a_q[W-1]}}, a_q};

	always_comb begin
		if (!b_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -a_ext;
		end else begin
			addend = a_ext;
		end
		sum = {hi_q[W], hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (run_q) begin
			hi_q <= sum[W+1:1];
			lo_q <= {sum[0], lo_q[W-1:1]};
			b_q  <= {1'b0, b_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q[W-1:0], lo_q};

endmodule

// File: hw/rtl/pidaw_div.sv
// ----------------------------------------------------------------------------
// pidaw_div
// Restoring unsigned divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pidaw_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pidaw_pkg::DIV_W-1:0]        num,
	input  logic [pidaw_pkg::DT_W-1:0]         den,
	output logic                               done,
	output logic [pidaw_pkg::DIV_W-1:0]        quo
);

	localparam int N = pidaw_pkg::DIV_W;
	localparam int D = pidaw_pkg::DT_W;

	logic                          run_q;
	logic                          done_q;
	logic [pidaw_pkg::DCNT_W-1:0]  cnt_q;
	logic [N-1:0]                  num_q;
	logic [D-1:0]                  den_q;
	logic [D-1:0]                  rem_q;
	logic [N-1:0]                  quo_q;
	logic [D:0]                    trial;
	logic [D+1:0]                  diff;
	logic                          fits;

	assign trial = {rem_q, num_q[N-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = ~diff[D+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pidaw_pkg::DCNT_W'(N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[N-2:0], 1'b0};
			rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hw/rtl/pid_controller_antiwindup_core.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_core
// PID controller with clamped integral, Q16.16, bit-serial arithmetic.
// A new request is taken only in idle, after the last drive value is loaded.
// Each request makes four passes through the shared bit-serial multiplier,
// with the divider running alongside.
// Reset clears the integral and last error and loads the gain and time-step defaults.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pidaw_pkg::DATA_W-1:0]    target_value,
	input  logic signed [pidaw_pkg::DATA_W-1:0]    measured_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pidaw_pkg::OUT_W-1:0]            drive_value,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0]           cfg_data
);

	localparam int DW = pidaw_pkg::DATA_W;
	localparam int MW = pidaw_pkg::MUL_W;
	localparam int FB = pidaw_pkg::FRAC_BITS;
	localparam int IW = pidaw_pkg::INTEG_W;
	localparam int SW = pidaw_pkg::SUM_W;
	localparam int TW = pidaw_pkg::TERM_W;
	localparam int XW = pidaw_pkg::ISUM_W;
	localparam int NW = pidaw_pkg::DIV_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MDT  = 3'd2;
	localparam logic [2:0] ST_MP   = 3'd3;
	localparam logic [2:0] ST_MI   = 3'd4;
	localparam logic [2:0] ST_MD   = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]                       state_q;
	logic signed [pidaw_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [pidaw_pkg::DT_W-1:0]       dt_q;
	logic signed [DW-1:0]             err_q;
	logic signed [DW-1:0]             last_err_q;
	logic signed [IW-1:0]             integ_q;
	logic signed [DW-1:0]             deriv_q;
	logic                             dneg_q;
	logic signed [SW-1:0]             sum_q;
	logic                             out_valid_q;
	logic [pidaw_pkg::OUT_W-1:0]      drive_q;

	logic signed [DW:0]               err_wide;
	logic signed [DW-1:0]             err_sat;
	logic signed [DW:0]               ediff;
	logic [DW:0]                      ediff_mag;
	logic [NW-1:0]                    div_num;
	logic [NW-1:0]                    div_quo;
	logic                             div_done;
	logic signed [DW-1:0]             deriv_nxt;

	logic                             mul_start;
	logic                             mul_done;
	logic signed [MW-1:0]             mul_a, mul_b;
	logic signed [pidaw_pkg::PROD_W-1:0] mul_prod;
	logic signed [XW-1:0]             isum;
	logic signed [IW-1:0]             integ_nxt;
	logic signed [SW-1:0]             term;
	logic signed [SW-1:0]             sum_nxt;
	logic                             out_load;
	logic                             accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// error with saturation
	always_comb begin
		err_wide = {target_value[DW-1], target_value} - {measured_value[DW-1], measured_value};
		if (err_wide[DW] != err_wide[DW-1]) begin
			err_sat = {err_wide[DW], {(DW-1){~err_wide[DW]}}};
		end else begin
			err_sat = err_wide[DW-1:0];
		end
	end

	// derivative numerator magnitude
	always_comb begin
		ediff     = {err_q[DW-1], err_q} - {last_err_q[DW-1], last_err_q};
		ediff_mag = ediff[DW] ? (DW+1)'(-ediff) : ediff;
		div_num   = {ediff_mag, {FB{1'b0}}};
	end

	pidaw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.num    (div_num),
		.den    (dt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// signed, saturated quotient
	always_comb begin
		if (dt_q == '0) begin
			deriv_nxt = '0;
		end else if (!dneg_q) begin
			if (div_quo[NW-1:DW-1] != '0) begin
				deriv_nxt = {1'b0, {(DW-1){1'b1}}};
			end else begin
				deriv_nxt = div_quo[DW-1:0];
			end
		end else begin
			if ((div_quo[NW-1:DW] != '0) || (div_quo[DW-1] && (div_quo[DW-2:0] != '0))) begin
				deriv_nxt = {1'b1, {(DW-1){1'b0}}};
			end else begin
				deriv_nxt = -div_quo[DW-1:0];
			end
		end
	end

	// multiplier operand select
	always_comb begin
		case (state_q)
			ST_LOAD: begin
				mul_a = {err_q[DW-1], err_q};
				mul_b = MW'({1'b0, dt_q});
			end
			ST_MDT: begin
				mul_a = {kp_q[DW-1], kp_q};
				mul_b = {err_q[DW-1], err_q};
			end
			ST_MP: begin
				mul_a = {ki_q[DW-1], ki_q};
				mul_b = {{(MW-IW){integ_q[IW-1]}}, integ_q};
			end
			ST_MI: begin
				mul_a = {kd_q[DW-1], kd_q};
				mul_b = {deriv_q[DW-1], deriv_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == ST_LOAD) ||
		(mul_done && ((state_q == ST_MDT) || (state_q == ST_MP) || (state_q == ST_MI)));

	pidaw_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// integral update and term accumulation
	always_comb begin
		isum = {{(XW-IW){integ_q[IW-1]}}, integ_q} + mul_prod[FB+XW-1:FB];
		if (isum > pidaw_pkg::ILIM) begin
			integ_nxt = IW'(pidaw_pkg::ILIM);
		end else if (isum < -pidaw_pkg::ILIM) begin
			integ_nxt = IW'(-pidaw_pkg::ILIM);
		end else begin
			integ_nxt = isum[IW-1:0];
		end
		term    = {{(SW-TW){mul_prod[FB+TW-1]}}, mul_prod[FB+TW-1:FB]};
		sum_nxt = (state_q == ST_MP) ? term : sum_q + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kp_q        <= pidaw_pkg::KP_RESET;
			ki_q        <= pidaw_pkg::KI_RESET;
			kd_q        <= pidaw_pkg::KD_RESET;
			dt_q        <= pidaw_pkg::DT_RESET;
			last_err_q  <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pidaw_pkg::REG_KP: kp_q <= cfg_data;
					pidaw_pkg::REG_KI: ki_q <= cfg_data;
					pidaw_pkg::REG_KD: kd_q <= cfg_data;
					pidaw_pkg::REG_DT: dt_q <= cfg_data[pidaw_pkg::DT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					last_err_q <= err_q;
					state_q    <= ST_MDT;
				end
				ST_MDT: begin
					if (mul_done) begin
						integ_q <= integ_nxt;
						state_q <= ST_MP;
					end
				end
				ST_MP: begin
					if (mul_done) begin
						state_q <= ST_MI;
					end
				end
				ST_MI: begin
					if (mul_done) begin
						state_q <= ST_MD;
					end
				end
				ST_MD: begin
					if (mul_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_sat;
		end
		if (state_q == ST_LOAD) begin
			dneg_q <= ediff[DW];
		end
		if (div_done) begin
			deriv_q <= deriv_nxt;
		end
		if (mul_done && ((state_q == ST_MP) || (state_q == ST_MI) || (state_q == ST_MD))) begin
			sum_q <= sum_nxt;
		end
		if (out_load) begin
			if (sum_q[SW-1]) begin
				drive_q <= '0;
			end else if (sum_q > pidaw_pkg::OLIM) begin
				drive_q <= pidaw_pkg::OUT_MAX;
			end else begin
				drive_q <= sum_q[pidaw_pkg::OUT_W-1:0];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;

endmodule

// File: hw/rtl/pidaw_chk.sv
// ----------------------------------------------------------------------------
// pidaw_chk
// Port-level checks for the PID core, bound to the top level.
// ----------------------------------------------------------------------------
module pidaw_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pidaw_pkg::OUT_W-1:0]   drive_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive_value))
		else $error("result changed while stalled");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_value <= pidaw_pkg::OUT_MAX)
		else $error("drive value above limit");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind pid_controller_antiwindup_core pidaw_chk u_pidaw_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.drive_value (drive_value)
);

// File: sim/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the sample, drive and register channels of the PID core. It keeps
// its own copy of the gains, time step, integral and last error, computes the
// drive value for every accepted sample request, and compares each accepted
// drive value against the oldest outstanding one.
// ----------------------------------------------------------------------------
module pid_drive_checker
	import pidaw_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [DATA_W-1:0]    target_value,
	input  logic signed [DATA_W-1:0]    measured_value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [OUT_W-1:0]            drive_value,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DATA_W-1:0]           cfg_data,
	output int                          mismatches,
	output int                          pending
);

	localparam longint S32_MAX   = 64'sd2147483647;
	localparam longint S32_MIN   = -64'sd2147483648;
	localparam longint INTEG_LIM = longint'(30) <<< FRAC_BITS;
	localparam longint DRIVE_LIM = longint'(200) <<< FRAC_BITS;

	logic signed [GAIN_W-1:0]  kp_gain;
	logic signed [GAIN_W-1:0]  ki_gain;
	logic signed [GAIN_W-1:0]  kd_gain;
	logic [DT_W-1:0]           step_size;
	logic signed [DATA_W-1:0]  prev_error;
	logic signed [INTEG_W-1:0] integ_acc;

	logic [OUT_W-1:0] drive_expected[$];

	function automatic logic [OUT_W-1:0] compute_drive(
		input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas
	);
		longint err, dt, integ, deriv, diff, sum, kp, ki, kd, last;
		err = longint'(tgt) - longint'(meas);
		if (err > S32_MAX) err = S32_MAX;
		if (err < S32_MIN) err = S32_MIN;
		dt = step_size;
		last = prev_error;
		integ = integ_acc;
		integ = integ + ((err * dt) >>> FRAC_BITS);
		if (integ > INTEG_LIM) integ = INTEG_LIM;
		if (integ < -INTEG_LIM) integ = -INTEG_LIM;
		deriv = 0;
		if (dt != 0) begin
			diff = err - last;
			deriv = (diff <<< FRAC_BITS) / dt;
			if (deriv > S32_MAX) deriv = S32_MAX;
			if (deriv < S32_MIN) deriv = S32_MIN;
		end
		prev_error = err[DATA_W-1:0];
		integ_acc = integ[INTEG_W-1:0];
		kp = kp_gain;
		ki = ki_gain;
		kd = kd_gain;
		sum = ((kp * err) >>> FRAC_BITS) + ((ki * integ) >>> FRAC_BITS)
			+ ((kd * deriv) >>> FRAC_BITS);
		if (sum > DRIVE_LIM) sum = DRIVE_LIM;
		if (sum < 0) sum = 0;
		return sum[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			kp_gain = KP_RESET;
			ki_gain = KI_RESET;
			kd_gain = KD_RESET;
			step_size = DT_RESET;
			prev_error = '0;
			integ_acc = '0;
			drive_expected.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP: kp_gain = cfg_data;
					REG_KI: ki_gain = cfg_data;
					REG_KD: kd_gain = cfg_data;
					REG_DT: step_size = cfg_data[DT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				drive_expected.push_back(compute_drive(target_value, measured_value));
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					if (mismatches < 10)
						$display("drive_value %0d with no request outstanding", drive_value);
					mismatches++;
				end else begin
					want = drive_expected.pop_front();
					if (drive_value !== want) begin
						if (mismatches < 10)
							$display("drive_value mismatch: expected %0d got %0d",
								want, drive_value);
						mismatches++;
					end
				end
			end
			pending = drive_expected.size();
		end
	end

endmodule

// File: sim/tb_pid_controller_antiwindup_core.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_antiwindup_core
// Drives the PID core with directed corner samples and register settings,
// then with random phases of gains, time steps and samples, under random
// stalls on both channels. A checker beside the core scores every drive value.
// ----------------------------------------------------------------------------
module tb_pid_controller_antiwindup_core;
	import pidaw_pkg::*;

	localparam int RUN_ITEMS = 1450;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [DATA_W-1:0] ONE     = 32'sd65536;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] target_value;
	logic signed [DATA_W-1:0] measured_value;
	logic                     out_valid;
	logic                     out_ready;
	logic [OUT_W-1:0]         drive_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	int                       mismatches;
	int                       pending;
	int                       sent;
	bit                       calm;

	pid_controller_antiwindup_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_value(target_value),
		.measured_value(measured_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pid_drive_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_value(target_value),
		.measured_value(measured_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom();
		if (r == 1) return VAL_MAX;
		if (r == 2) return VAL_MIN;
		if (r == 3) return '0;
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	function automatic logic [DATA_W-1:0] pick_step();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return 32'h00ffffff;
		if (r == 2) return $urandom();
		return $urandom_range(1, 4000);
	endfunction

	task automatic pick_sample(output logic signed [DATA_W-1:0] tgt,
		output logic signed [DATA_W-1:0] meas);
		int r, base, err;
		r = $urandom_range(0, 19);
		if (r < 2) begin
			tgt = $urandom();
			meas = $urandom();
		end else if (r == 2) begin
			tgt = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			meas = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		end else begin
			base = $urandom_range(0, 1 << 26) - (1 << 25);
			err = $urandom_range(0, 1 << 20) - (1 << 19);
			tgt = base + err;
			meas = base;
		end
	endtask

	task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
		input logic signed [DATA_W-1:0] meas);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		target_value <= tgt;
		measured_value <= meas;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop the request and hold until every drive value is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_gains(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
		input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] step);
		settle();
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_DT, step);
	endtask

	initial begin
		int hold;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	initial begin
		logic signed [DATA_W-1:0] tgt, meas;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_value = '0;
		measured_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_KP;
		cfg_data = '0;
		calm = 1'b0;
		sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_sample(0, 0);
		send_sample(100 * ONE, 0);
		send_sample(250 * ONE, 0);
		send_sample(0, 5 * ONE);
		send_sample(VAL_MAX, VAL_MIN);
		send_sample(VAL_MIN, VAL_MAX);
		send_sample(VAL_MAX, VAL_MAX);

		// zero time step: no derivative, integral frozen
		load_gains(VAL_MAX, VAL_MIN, ONE, '0);
		send_sample(3 * ONE, 0);
		send_sample(-3 * ONE, 0);
		send_sample(VAL_MIN, VAL_MIN);

		// drive the integral into both clamps
		load_gains('0, ONE, '0, 32'h00ffffff);
		send_sample(VAL_MAX, 0);
		send_sample(VAL_MAX, 0);
		send_sample(VAL_MIN, 0);
		send_sample(VAL_MIN, 0);
		send_sample(ONE, 0);

		// saturate the derivative both ways
		load_gains('0, '0, VAL_MIN, 1);
		send_sample(VAL_MAX, 0);
		send_sample(VAL_MIN, 0);
		send_sample(0, 0);

		load_gains(2 * ONE, ONE / 2, ONE / 4, 655);
		send_sample(10 * ONE, 2 * ONE);
		send_sample(3 * ONE, 0);

		while (sent < RUN_ITEMS) begin
			calm = 1'b0;
			load_gains(pick_gain(), pick_gain(), pick_gain(), pick_step());
			calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 160);
			if (n > RUN_ITEMS - sent) n = RUN_ITEMS - sent;
			repeat (n) begin
				if ($urandom_range(0, 99) == 0) settle();
				pick_sample(tgt, meas);
				send_sample(tgt, meas);
				sent++;
			end
		end
		calm = 1'b0;

		settle();
		repeat (150) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
